>>> rtl/core/bfk_pkg.sv
// ----------------------------------------------------------------------------
// bfk_pkg
// Shared types and constants for the key table cipher engine.
// ----------------------------------------------------------------------------
package bfk_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_ENCRYPT = 2'd1,
    FUNC_DECRYPT = 2'd2,
    FUNC_KEYCODE = 2'd3
  } func_t;

  localparam int unsigned TABLE_WORDS = 1042;
  localparam int unsigned IDX_W       = 11;

  localparam logic [IDX_W-1:0] SBOX0      = 11'h012;
  localparam logic [IDX_W-1:0] SBOX1      = 11'h112;
  localparam logic [IDX_W-1:0] SBOX2      = 11'h212;
  localparam logic [IDX_W-1:0] SBOX3      = 11'h312;
  localparam logic [IDX_W-1:0] TABLE_LAST = 11'h411;
  localparam logic [IDX_W-1:0] REGEN_LAST = 11'h410;
  localparam logic [IDX_W-1:0] P_LAST     = 11'h011;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

>>> rtl/core/blowfish_key1_cipher_engine.sv
// ----------------------------------------------------------------------------
// blowfish_key1_cipher_engine
// 64-bit Feistel block cipher over a 1042-word key table in one synchronous
// memory with one read and one write port; also applies three-word key codes.
// ----------------------------------------------------------------------------
//   channel | signals                                   | direction
//   input   | valid stall func table_index word_a/b/c   | in (stall out)
//   output  | out_valid out_stall out_a out_b out_c     | out (stall in)
//
// One memory read per cycle sets the pace: a round reads the P word, then the
// four S-box words, then combines them. Encrypt and decrypt run 16 rounds
// before their result; a key code encrypts the key words twice, XORs the
// byte-swapped key into the P words and regenerates the table by 521
// encryptions. Reset idles the engine; the table is undefined until written.
// A held result blocks new requests only until taken.
module blowfish_key1_cipher_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    stall,
  input  logic [1:0]              func,
  input  logic [10:0]             table_index,
  input  logic [31:0]             word_a,
  input  logic [31:0]             word_b,
  input  logic [31:0]             word_c,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             out_a,
  output logic [31:0]             out_b,
  output logic [31:0]             out_c
);
  import bfk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RP, S_RS0, S_RS1, S_RS2, S_RS3, S_RF, S_FIN0, S_FIN1, S_FIN2,
    S_PX_RD, S_PX_WR, S_ST_HI, S_ST_LO, S_DONE
  } state_t;

  // which block op runs: a user request or a step of a key code
  typedef enum logic [1:0] {PH_USER, PH_K12, PH_K01, PH_REGEN} phase_t;

  logic [31:0] mem [TABLE_WORDS];
  logic [31:0] rdata;
  logic [10:0] raddr;
  logic        we;
  logic [10:0] waddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t      state;
  phase_t      phase;
  logic        dec;
  logic [3:0]  rnd;
  logic [31:0] x, y, z, v;
  logic [31:0] k0, k1, k2;
  logic [10:0] ptr;
  logic        out_load;
  logic        we_next;

  logic [10:0] pidx;
  assign pidx = dec ? (P_LAST - {7'd0, rnd}) : {7'd0, rnd};

  logic [31:0] z_rp;
  assign z_rp = rdata ^ x;

  always_comb begin
    raddr = 11'd0;
    unique case (state)
      S_RP:    raddr = SBOX0 + {3'd0, z_rp[31:24]};
      S_RS0:   raddr = SBOX1 + {3'd0, z[23:16]};
      S_RS1:   raddr = SBOX2 + {3'd0, z[15:8]};
      S_RS2:   raddr = SBOX3 + {3'd0, z[7:0]};
      S_FIN0:  raddr = dec ? 11'd1 : 11'd16;
      S_FIN1:  raddr = dec ? 11'd0 : 11'd17;
      S_PX_RD: raddr = ptr;
      S_PX_WR: raddr = ptr + 11'd1;
      default: raddr = pidx;
    endcase
  end

  assign stall = (state != S_IDLE) || (out_valid && out_stall);

  // result load and table write strobes
  always_comb begin
    out_load = 1'b0;
    we_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        out_load = valid && !stall && (func_t'(func) == FUNC_WRITE);
        we_next  = out_load && (table_index <= TABLE_LAST);
      end
      S_FIN2:           out_load = (phase == PH_USER);
      S_PX_WR, S_ST_HI: we_next = 1'b1;
      S_ST_LO: begin
        we_next  = 1'b1;
        out_load = (ptr == REGEN_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      we        <= 1'b0;
    end else begin
      we <= we_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (valid && !stall) begin
          rnd <= 4'd0;
          k0 <= word_a; k1 <= word_b; k2 <= word_c;
          unique case (func_t'(func))
            FUNC_WRITE: begin
              waddr <= table_index; wdata <= word_a;
              out_a <= '0; out_b <= '0; out_c <= '0;
            end
            FUNC_ENCRYPT, FUNC_DECRYPT: begin
              dec <= (func_t'(func) == FUNC_DECRYPT);
              phase <= PH_USER; x <= word_b; y <= word_a; state <= S_RF;
            end
            default: begin
              dec <= 1'b0; phase <= PH_K12; x <= word_c; y <= word_b;
              state <= S_RF;
            end
          endcase
        end
        // S_RF issues the P read for the current round
        S_RF: state <= S_RP;
        S_RP: begin z <= z_rp; state <= S_RS0; end
        S_RS0: begin v <= rdata; state <= S_RS1; end
        S_RS1: begin v <= rdata + v; state <= S_RS2; end
        S_RS2: begin v <= rdata ^ v; state <= S_RS3; end
        S_RS3: begin
          x   <= (rdata + v) ^ y;
          y   <= z;
          rnd <= rnd + 4'd1;
          state <= (rnd == 4'd15) ? S_FIN0 : S_RF;
        end
        S_FIN0: state <= S_FIN1;
        S_FIN1: begin x <= x ^ rdata; state <= S_FIN2; end
        S_FIN2: begin
          // x is the new low word, y ^ rdata the new high word
          rnd <= 4'd0;
          unique case (phase)
            PH_USER: begin
              out_a <= x; out_b <= y ^ rdata; out_c <= '0;
              state <= S_IDLE;
            end
            PH_K12: begin
              k1 <= x; k2 <= y ^ rdata; phase <= PH_K01; state <= S_DONE;
            end
            PH_K01: begin
              k0 <= x; k1 <= y ^ rdata; ptr <= 11'd0; state <= S_PX_RD;
            end
            default: begin
              z <= y ^ rdata; state <= S_ST_HI;
            end
          endcase
        end
        // second code encrypt: load (lo=k0, hi=k1)
        S_DONE: begin x <= k1; y <= k0; state <= S_RF; end
        S_PX_RD: begin
          // first P word read is in flight
          state <= S_PX_WR;
        end
        S_PX_WR: begin
          waddr <= ptr;
          wdata <= rdata ^ bswap32(ptr[0] ? k1 : k0);
          if (ptr == P_LAST) begin
            phase <= PH_REGEN; x <= '0; y <= '0; ptr <= 11'd0; state <= S_RF;
          end else begin
            ptr <= ptr + 11'd1;
          end
        end
        S_ST_HI: begin
          waddr <= ptr; wdata <= z; state <= S_ST_LO;
        end
        default: begin // S_ST_LO
          waddr <= ptr + 11'd1; wdata <= x;
          ptr <= ptr + 11'd2;
          if (ptr == REGEN_LAST) begin
            out_a <= k0; out_b <= k1; out_c <= k2;
            state <= S_IDLE;
          end else begin
            y <= x; x <= z; state <= S_RF;
          end
        end
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_a))
    else $error("result dropped while stalled");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> stall)
    else $error("request taken while busy");
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr <= TABLE_LAST)
    else $error("table write out of range");

endmodule
